>>> rtl/core/afs_pkg.sv
// afs_pkg: shared types, codes and reset constants of the amplifier fault supervisor.
// Used by afs_cfg_regs, afs_update and amp_fault_supervisor_top; depends on nothing.

package afs_pkg;

    // Item kinds carried on the mode field; code three means nothing
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_CLASSD = 2'd1,
        MODE_SUPPLY = 2'd2
    } t_mode;

    localparam logic [1:0] HOST_SHUTDOWN = 2'd2;

    // Register indexes, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_OV_PROTECT = 3'd0,
        REG_OV_RECOVER = 3'd1,
        REG_OV_WARNING = 3'd2,
        REG_UV_PROTECT = 3'd3,
        REG_UV_RECOVER = 3'd4,
        REG_UV_WARNING = 3'd5,
        REG_TH_PROTECT = 3'd6,
        REG_TH_RECOVER = 3'd7
    } t_reg_idx;

    localparam int ADDR_W = 5;

    // Fault flag bit positions
    localparam int F_OV   = 0;
    localparam int F_UV   = 1;
    localparam int F_TH   = 2;
    localparam int F_OCD  = 3;
    localparam int F_OCPS = 4;

    // Warning flag bit positions
    localparam int W_OV = 0;
    localparam int W_UV = 1;
    localparam int W_TH = 2;

    localparam logic [15:0]        OV_PROTECT_RST = 16'd65535;
    localparam logic [15:0]        OV_RECOVER_RST = 16'd65000;
    localparam logic [15:0]        OV_WARNING_RST = 16'd64000;
    localparam logic [15:0]        UV_PROTECT_RST = 16'd0;
    localparam logic [15:0]        UV_RECOVER_RST = 16'd500;
    localparam logic [15:0]        UV_WARNING_RST = 16'd1000;
    localparam logic signed [8:0]  TH_PROTECT_RST = 9'sd100;
    localparam logic signed [8:0]  TH_RECOVER_RST = 9'sd85;

    typedef struct packed {
        logic [15:0]       ov_protect;
        logic [15:0]       ov_recover;
        logic [15:0]       ov_warning;
        logic [15:0]       uv_protect;
        logic [15:0]       uv_recover;
        logic [15:0]       uv_warning;
        logic signed [8:0] th_protect;
        logic signed [8:0] th_recover;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        mode;
        logic [1:0]        host_state;
        logic [15:0]       battery_voltage;
        logic signed [8:0] temperature;
        logic [15:0]       elapsed_ms;
        logic              classd_fault;
    } t_item;

    typedef struct packed {
        logic [4:0]  fault;
        logic [2:0]  warning;
        logic        active;
        logic [1:0]  saved_host;
        logic [15:0] ptime;
        logic        supply_on;
        logic        stage_off;
    } t_state;

    // Per-item pulses that go with the state snapshot
    typedef struct packed {
        logic left;
        logic off;
    } t_pulse;

    localparam t_state STATE_RST = '{
        fault:      5'd0,
        warning:    3'd0,
        active:     1'b0,
        saved_host: 2'd0,
        ptime:      16'd0,
        supply_on:  1'b1,
        stage_off:  1'b0
    };

endpackage

>>> rtl/core/afs_cfg_regs.sv
// afs_cfg_regs: APB-style register file holding the comparator levels.
// Depends on afs_pkg for the register indexes, the level struct and reset values.

module afs_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [afs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output afs_pkg::t_cfg              o_cfg
);

    afs_pkg::t_cfg    r_cfg;
    afs_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = afs_pkg::t_reg_idx'(paddr[afs_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ov_protect <= afs_pkg::OV_PROTECT_RST;
            r_cfg.ov_recover <= afs_pkg::OV_RECOVER_RST;
            r_cfg.ov_warning <= afs_pkg::OV_WARNING_RST;
            r_cfg.uv_protect <= afs_pkg::UV_PROTECT_RST;
            r_cfg.uv_recover <= afs_pkg::UV_RECOVER_RST;
            r_cfg.uv_warning <= afs_pkg::UV_WARNING_RST;
            r_cfg.th_protect <= afs_pkg::TH_PROTECT_RST;
            r_cfg.th_recover <= afs_pkg::TH_RECOVER_RST;
        end else if (w_wr) begin
            case (w_idx)
                afs_pkg::REG_OV_PROTECT: r_cfg.ov_protect <= pwdata[15:0];
                afs_pkg::REG_OV_RECOVER: r_cfg.ov_recover <= pwdata[15:0];
                afs_pkg::REG_OV_WARNING: r_cfg.ov_warning <= pwdata[15:0];
                afs_pkg::REG_UV_PROTECT: r_cfg.uv_protect <= pwdata[15:0];
                afs_pkg::REG_UV_RECOVER: r_cfg.uv_recover <= pwdata[15:0];
                afs_pkg::REG_UV_WARNING: r_cfg.uv_warning <= pwdata[15:0];
                afs_pkg::REG_TH_PROTECT: r_cfg.th_protect <= $signed(pwdata[8:0]);
                afs_pkg::REG_TH_RECOVER: r_cfg.th_recover <= $signed(pwdata[8:0]);
                default: ;
            endcase
        end
    end

    // Temperatures read back sign-extended
    always_comb begin
        case (w_idx)
            afs_pkg::REG_OV_PROTECT: prdata = {16'd0, r_cfg.ov_protect};
            afs_pkg::REG_OV_RECOVER: prdata = {16'd0, r_cfg.ov_recover};
            afs_pkg::REG_OV_WARNING: prdata = {16'd0, r_cfg.ov_warning};
            afs_pkg::REG_UV_PROTECT: prdata = {16'd0, r_cfg.uv_protect};
            afs_pkg::REG_UV_RECOVER: prdata = {16'd0, r_cfg.uv_recover};
            afs_pkg::REG_UV_WARNING: prdata = {16'd0, r_cfg.uv_warning};
            afs_pkg::REG_TH_PROTECT: prdata = 32'(r_cfg.th_protect);
            afs_pkg::REG_TH_RECOVER: prdata = 32'(r_cfg.th_recover);
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/core/afs_update.sv
// afs_update: single-pass next-state logic of the supervisor for one item.
// Depends on afs_pkg for the item, level and state structs and the flag positions.

module afs_update #(
    parameter int RECOVER_PERIOD_MS = 3000,
    parameter int WARN_TEMP         = 75
) (
    input  afs_pkg::t_item  i_item,
    input  afs_pkg::t_cfg   i_cfg,
    input  afs_pkg::t_state i_st,
    output afs_pkg::t_state o_st,
    output afs_pkg::t_pulse o_pulse
);

    localparam logic [15:0]       RecoverMs = 16'(RECOVER_PERIOD_MS);
    localparam logic signed [8:0] WarnTemp  = 9'(WARN_TEMP);

    // Apply the protection drives; save the host state only on first entry
    function automatic afs_pkg::t_state f_enter(afs_pkg::t_state s, logic [1:0] host);
        afs_pkg::t_state r;
        r = s;
        if (s.fault[afs_pkg::F_UV] || s.fault[afs_pkg::F_OV] || s.fault[afs_pkg::F_OCPS]) begin
            r.supply_on = 1'b0;
            r.stage_off = 1'b1;
        end
        if (s.fault[afs_pkg::F_TH] || s.fault[afs_pkg::F_OCD]) begin
            r.stage_off = 1'b1;
        end
        if (!s.active) begin
            r.saved_host = host;
            r.active     = 1'b1;
        end
        return r;
    endfunction

    afs_pkg::t_state  n_st;
    logic [16:0]      w_sum;
    logic [15:0]      w_vb;
    logic signed [8:0] w_temp;

    assign w_vb   = i_item.battery_voltage;
    assign w_temp = i_item.temperature;
    assign w_sum  = {1'b0, i_st.ptime} + {1'b0, i_item.elapsed_ms};

    always_comb begin
        n_st    = i_st;
        o_pulse = '0;
        case (afs_pkg::t_mode'(i_item.mode))
            afs_pkg::MODE_TICK: begin
                if (i_st.active || i_item.host_state != afs_pkg::HOST_SHUTDOWN) begin
                    if (i_st.active) begin
                        n_st.ptime = w_sum[16] ? 16'hFFFF : w_sum[15:0];
                    end else begin
                        n_st.ptime = 16'd0;
                    end

                    // over-voltage band
                    if (w_vb >= i_cfg.ov_protect) begin
                        n_st.fault[afs_pkg::F_OV]   = 1'b1;
                        n_st.warning[afs_pkg::W_OV] = 1'b0;
                    end else if (w_vb > i_cfg.ov_recover) begin
                        n_st.warning[afs_pkg::W_OV] = !i_st.fault[afs_pkg::F_OV];
                    end else if (w_vb < i_cfg.ov_recover && w_vb >= i_cfg.ov_warning) begin
                        n_st.fault[afs_pkg::F_OV]   = 1'b0;
                        n_st.warning[afs_pkg::W_OV] = 1'b1;
                    end else begin
                        n_st.fault[afs_pkg::F_OV]   = 1'b0;
                        n_st.warning[afs_pkg::W_OV] = 1'b0;
                    end

                    // under-voltage band
                    if (w_vb <= i_cfg.uv_protect) begin
                        n_st.fault[afs_pkg::F_UV]   = 1'b1;
                        n_st.warning[afs_pkg::W_UV] = 1'b0;
                    end else if (w_vb < i_cfg.uv_recover) begin
                        n_st.warning[afs_pkg::W_UV] = !i_st.fault[afs_pkg::F_UV];
                    end else if (w_vb <= i_cfg.uv_warning) begin
                        n_st.fault[afs_pkg::F_UV]   = 1'b0;
                        n_st.warning[afs_pkg::W_UV] = 1'b1;
                    end else begin
                        n_st.fault[afs_pkg::F_UV]   = 1'b0;
                        n_st.warning[afs_pkg::W_UV] = 1'b0;
                    end

                    // thermal band; warning holds in the top band
                    if (w_temp >= i_cfg.th_protect) begin
                        n_st.fault[afs_pkg::F_TH] = 1'b1;
                    end else if (w_temp > i_cfg.th_recover) begin
                        n_st.warning[afs_pkg::W_TH] = !i_st.fault[afs_pkg::F_TH];
                    end else if (w_temp >= WarnTemp) begin
                        n_st.fault[afs_pkg::F_TH]   = 1'b0;
                        n_st.warning[afs_pkg::W_TH] = 1'b1;
                    end else begin
                        n_st.fault[afs_pkg::F_TH]   = 1'b0;
                        n_st.warning[afs_pkg::W_TH] = 1'b0;
                    end

                    if (n_st.fault != 5'd0) begin
                        if (!i_st.active) begin
                            n_st = f_enter(n_st, i_item.host_state);
                        end else if (n_st.ptime > RecoverMs) begin
                            // recovery period over: re-check the class-D pin
                            n_st.ptime = 16'd0;
                            if (n_st.fault[afs_pkg::F_OCD] && !i_item.classd_fault) begin
                                n_st.fault[afs_pkg::F_OCD] = 1'b0;
                            end
                        end
                    end else if (i_st.active) begin
                        n_st.active    = 1'b0;
                        n_st.supply_on = 1'b1;
                        n_st.stage_off = 1'b0;
                        o_pulse.left   = 1'b1;
                    end
                end
            end
            afs_pkg::MODE_CLASSD: begin
                if (i_item.classd_fault) begin
                    n_st.fault[afs_pkg::F_OCD] = 1'b1;
                    n_st = f_enter(n_st, i_item.host_state);
                end
            end
            afs_pkg::MODE_SUPPLY: begin
                n_st.fault[afs_pkg::F_OCPS] = 1'b1;
                n_st        = f_enter(n_st, i_item.host_state);
                o_pulse.off = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_st = n_st;

endmodule

>>> rtl/core/amp_fault_supervisor_top.sv
// amp_fault_supervisor_top: amplifier fault supervisor, input register, update logic,
// result register. Depends on afs_pkg, afs_cfg_regs and afs_update.
//
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_ready   mode, host_state, battery_voltage,
//                                                 temperature, elapsed_ms, classd_fault
//  out       source     o_out_valid / i_out_ready in_protection, leave_protection,
//                                                 restore_state, supply_enable,
//                                                 classd_disable, amp_off, fault/warning
//  cfg       APB slave  psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// Flow: one beat per clock sustained while i_out_ready is high; an accepted beat is
//   loaded into the input register, and the update logic loads the result and state
//   registers from it when that beat advances.
// The rate is set by the state feedback loop: the update of one item is combinational
//   and reads the state registers written by the item before it.
// Reset: synchronous, active low; clears both valid flags, the state (supply running)
//   and the levels to their defaults.
// Stalls: a full result register holds while i_out_ready is low; the input register then
//   holds its beat and o_in_ready drops only when both stages are full.

module amp_fault_supervisor_top #(
    parameter int RECOVER_PERIOD_MS = 3000,
    parameter int WARN_TEMP         = 75
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input beats
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_mode,
    input  logic [1:0]                 i_host_state,
    input  logic [15:0]                i_battery_voltage,
    input  logic signed [8:0]          i_temperature,
    input  logic [15:0]                i_elapsed_ms,
    input  logic                       i_classd_fault,
    // result beats
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_in_protection,
    output logic                       o_leave_protection,
    output logic [1:0]                 o_restore_state,
    output logic                       o_supply_enable,
    output logic                       o_classd_disable,
    output logic                       o_amp_off,
    output logic [4:0]                 o_fault_flags,
    output logic [2:0]                 o_warning_flags,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [afs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    afs_pkg::t_cfg   w_cfg;
    afs_pkg::t_item  r_item;
    logic            r_in_vld;
    afs_pkg::t_state r_st;
    afs_pkg::t_state n_st;
    afs_pkg::t_pulse n_pulse;
    afs_pkg::t_state r_res;
    afs_pkg::t_pulse r_res_pulse;
    logic            r_out_vld;
    logic            w_adv;

    afs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    afs_update #(
        .RECOVER_PERIOD_MS (RECOVER_PERIOD_MS),
        .WARN_TEMP         (WARN_TEMP)
    ) u_update (
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .i_st    (r_st),
        .o_st    (n_st),
        .o_pulse (n_pulse)
    );

    // Advance the held beat when the result register is free or draining
    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.mode            <= i_mode;
            r_item.host_state      <= i_host_state;
            r_item.battery_voltage <= i_battery_voltage;
            r_item.temperature     <= i_temperature;
            r_item.elapsed_ms      <= i_elapsed_ms;
            r_item.classd_fault    <= i_classd_fault;
        end
    end

    // State and result registers; commit state once per advanced beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= afs_pkg::STATE_RST;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_st      <= n_st;
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res       <= n_st;
            r_res_pulse <= n_pulse;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_in_protection    = r_res.active;
    assign o_leave_protection = r_res_pulse.left;
    assign o_restore_state    = r_res.saved_host;
    assign o_supply_enable    = r_res.supply_on;
    assign o_classd_disable   = r_res.stage_off;
    assign o_amp_off          = r_res_pulse.off;
    assign o_fault_flags      = r_res.fault;
    assign o_warning_flags    = r_res.warning;

    // Any set fault flag means the block is in protection
    a_fault_implies_prot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_fault_flags != 5'd0) |-> o_in_protection)
        else $error("fault flag set outside protection");

    // Leaving protection leaves the drives released
    a_leave_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_leave_protection |->
            !o_in_protection && o_supply_enable && !o_classd_disable)
        else $error("leave pulse with protection drives active");

    // Power-off request comes with the supply dropped and the stage disabled
    a_off_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_amp_off |-> !o_supply_enable && o_classd_disable)
        else $error("amp_off without protection drives");

    // Supply over-current latch never clears
    a_ocps_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_st.fault[afs_pkg::F_OCPS]) |->
            r_st.fault[afs_pkg::F_OCPS])
        else $error("supply current latch cleared");

    // An empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

>>> test/amp_fault_supervisor_top_tb.sv
// amp_fault_supervisor_top_tb: self-checking bench for the amplifier fault supervisor.
// Depends on afs_pkg and amp_fault_supervisor_top; drives beats with random gaps and
// checks every result beat against a cycle-free model of the supervisor.

module amp_fault_supervisor_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RECOVER_MS = 3000;
    localparam int HOT_WARN   = 75;
    // Hard time limit for the whole run, in nanoseconds.
    localparam int LIMIT_NS   = 12_000_000;

    // Host states the package leaves unnamed, and the mode code the block ignores
    localparam logic [1:0] HOST_INIT   = 2'd0;
    localparam logic [1:0] HOST_NORMAL = 2'd1;
    localparam logic [1:0] HOST_OTHER  = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic       in_prot;
        logic       left;
        logic [1:0] restore;
        logic       supply_en;
        logic       stage_dis;
        logic       amp_off;
        logic [4:0] fault;
        logic [2:0] warn;
    } t_status;

    logic                       i_clk             = 1'b0;
    logic                       i_rst_n           = 1'b0;
    logic                       i_in_valid        = 1'b0;
    logic                       o_in_ready;
    logic [1:0]                 i_mode            = '0;
    logic [1:0]                 i_host_state      = '0;
    logic [15:0]                i_battery_voltage = '0;
    logic signed [8:0]          i_temperature     = '0;
    logic [15:0]                i_elapsed_ms      = '0;
    logic                       i_classd_fault    = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready       = 1'b0;
    logic                       o_in_protection;
    logic                       o_leave_protection;
    logic [1:0]                 o_restore_state;
    logic                       o_supply_enable;
    logic                       o_classd_disable;
    logic                       o_amp_off;
    logic [4:0]                 o_fault_flags;
    logic [2:0]                 o_warning_flags;
    logic                       psel              = 1'b0;
    logic                       penable           = 1'b0;
    logic                       pwrite            = 1'b0;
    logic [afs_pkg::ADDR_W-1:0] paddr             = '0;
    logic [31:0]                pwdata            = '0;
    logic [31:0]                prdata;
    logic                       pready;

    // Model copy of the levels and of the supervisor state
    afs_pkg::t_cfg    lvl;
    afs_pkg::t_state  sup;

    afs_pkg::t_item   pending_items[$];
    t_status          expected_status[$];
    afs_pkg::t_item   drv_item;

    int      items_queued   = 0;
    int      beats_in       = 0;
    int      errors         = 0;
    int      tx_gap         = 0;
    int      tx_quiet       = 0;
    int      rx_wait        = 0;
    int      rx_quiet       = 0;
    logic    hold_off       = 1'b0;
    logic    in_beat;
    logic    out_beat;
    t_status want;

    amp_fault_supervisor_top #(
        .RECOVER_PERIOD_MS(RECOVER_MS),
        .WARN_TEMP(HOT_WARN)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_mode(i_mode),
        .i_host_state(i_host_state),
        .i_battery_voltage(i_battery_voltage),
        .i_temperature(i_temperature),
        .i_elapsed_ms(i_elapsed_ms),
        .i_classd_fault(i_classd_fault),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_in_protection(o_in_protection),
        .o_leave_protection(o_leave_protection),
        .o_restore_state(o_restore_state),
        .o_supply_enable(o_supply_enable),
        .o_classd_disable(o_classd_disable),
        .o_amp_off(o_amp_off),
        .o_fault_flags(o_fault_flags),
        .o_warning_flags(o_warning_flags),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Supervisor model
    // ------------------------------------------------------------------

    // Apply the protection drives; keep the saved host state on re-entry.
    function automatic void enter_protection(logic [1:0] host);
        if (sup.fault[afs_pkg::F_UV] || sup.fault[afs_pkg::F_OV] ||
            sup.fault[afs_pkg::F_OCPS]) begin
            sup.supply_on = 1'b0;
            sup.stage_off = 1'b1;
        end
        if (sup.fault[afs_pkg::F_TH] || sup.fault[afs_pkg::F_OCD])
            sup.stage_off = 1'b1;
        if (!sup.active) begin
            sup.saved_host = host;
            sup.active     = 1'b1;
        end
    endfunction

    // Advance the model by one beat and return the status it must report.
    function automatic t_status supervise_step(afs_pkg::t_item it);
        t_status     r;
        logic [16:0] ptime_sum;
        int          vb;
        int          t_now;
        int          t_hot;
        int          t_cool;
        logic        left_now;
        logic        off_now;
        left_now = 1'b0;
        off_now  = 1'b0;
        vb       = it.battery_voltage;
        t_now    = $signed(it.temperature);
        t_hot    = $signed(lvl.th_protect);
        t_cool   = $signed(lvl.th_recover);

        if (it.mode == afs_pkg::MODE_TICK &&
            (sup.active || it.host_state != afs_pkg::HOST_SHUTDOWN)) begin
            // Protection time only runs while protected; saturate at the top.
            if (sup.active) begin
                ptime_sum = sup.ptime + it.elapsed_ms;
                sup.ptime = ptime_sum[16] ? 16'hFFFF : ptime_sum[15:0];
            end else begin
                sup.ptime = '0;
            end

            if (vb >= lvl.ov_protect) begin
                sup.fault[afs_pkg::F_OV] = 1'b1;
                sup.warning[afs_pkg::W_OV] = 1'b0;
            end else if (vb > lvl.ov_recover) begin
                sup.warning[afs_pkg::W_OV] = !sup.fault[afs_pkg::F_OV];
            end else if (vb < lvl.ov_recover && vb >= lvl.ov_warning) begin
                sup.fault[afs_pkg::F_OV] = 1'b0;
                sup.warning[afs_pkg::W_OV] = 1'b1;
            end else begin
                sup.fault[afs_pkg::F_OV] = 1'b0;
                sup.warning[afs_pkg::W_OV] = 1'b0;
            end

            if (vb <= lvl.uv_protect) begin
                sup.fault[afs_pkg::F_UV] = 1'b1;
                sup.warning[afs_pkg::W_UV] = 1'b0;
            end else if (vb < lvl.uv_recover) begin
                sup.warning[afs_pkg::W_UV] = !sup.fault[afs_pkg::F_UV];
            end else if (vb <= lvl.uv_warning) begin
                sup.fault[afs_pkg::F_UV] = 1'b0;
                sup.warning[afs_pkg::W_UV] = 1'b1;
            end else begin
                sup.fault[afs_pkg::F_UV] = 1'b0;
                sup.warning[afs_pkg::W_UV] = 1'b0;
            end

            // Top band leaves the thermal warning alone
            if (t_now >= t_hot) begin
                sup.fault[afs_pkg::F_TH] = 1'b1;
            end else if (t_now > t_cool) begin
                sup.warning[afs_pkg::W_TH] = !sup.fault[afs_pkg::F_TH];
            end else if (t_now >= HOT_WARN) begin
                sup.warning[afs_pkg::W_TH] = 1'b1;
                sup.fault[afs_pkg::F_TH] = 1'b0;
            end else begin
                sup.warning[afs_pkg::W_TH] = 1'b0;
                sup.fault[afs_pkg::F_TH] = 1'b0;
            end

            if (sup.fault != '0) begin
                if (!sup.active) begin
                    enter_protection(it.host_state);
                end else if (sup.ptime > RECOVER_MS) begin
                    // Re-check the class-D pin once per recovery period
                    sup.ptime = '0;
                    if (sup.fault[afs_pkg::F_OCD] && !it.classd_fault)
                        sup.fault[afs_pkg::F_OCD] = 1'b0;
                end
            end else if (sup.active) begin
                sup.active    = 1'b0;
                sup.supply_on = 1'b1;
                sup.stage_off = 1'b0;
                left_now      = 1'b1;
            end
        end else if (it.mode == afs_pkg::MODE_CLASSD) begin
            if (it.classd_fault) begin
                sup.fault[afs_pkg::F_OCD] = 1'b1;
                enter_protection(it.host_state);
            end
        end else if (it.mode == afs_pkg::MODE_SUPPLY) begin
            sup.fault[afs_pkg::F_OCPS] = 1'b1;
            enter_protection(it.host_state);
            off_now = 1'b1;
        end

        r.in_prot   = sup.active;
        r.left      = left_now;
        r.restore   = sup.saved_host;
        r.supply_en = sup.supply_on;
        r.stage_dis = sup.stage_off;
        r.amp_off   = off_now;
        r.fault     = sup.fault;
        r.warn      = sup.warning;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length between beats: mostly none or short, a few long, and now and
    // then a quiet stretch with no idling at all.
    function automatic int pick_idle(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet = $urandom_range(40, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [1:0] pick_host();
        logic [1:0] h;
        if ($urandom_range(0, 99) < 15) return afs_pkg::HOST_SHUTDOWN;
        case ($urandom_range(0, 2))
            0:       h = HOST_INIT;
            1:       h = HOST_NORMAL;
            default: h = HOST_OTHER;
        endcase
        return h;
    endfunction

    function automatic int nominal_voltage();
        return (int'(lvl.uv_warning) + int'(lvl.ov_warning)) / 2;
    endfunction

    // Battery levels cluster around the configured band edges.
    function automatic int pick_voltage();
        int lv[6];
        int r;
        int v;
        lv = '{lvl.ov_protect, lvl.ov_recover, lvl.ov_warning,
               lvl.uv_protect, lvl.uv_recover, lvl.uv_warning};
        r = $urandom_range(0, 99);
        if (r < 45)
            v = lv[$urandom_range(0, 5)] + int'($urandom_range(0, 4)) - 2;
        else if (r < 65)
            v = nominal_voltage();
        else if (r < 92)
            v = $urandom_range(0, 65535);
        else
            v = $urandom_range(0, 1) ? 65535 : 0;
        return v < 0 ? 0 : (v > 65535 ? 65535 : v);
    endfunction

    function automatic int pick_temp();
        int r;
        int t;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            case ($urandom_range(0, 2))
                0:       t = $signed(lvl.th_protect);
                1:       t = $signed(lvl.th_recover);
                default: t = HOT_WARN;
            endcase
            t = t + int'($urandom_range(0, 4)) - 2;
        end else if (r < 70) begin
            t = HOT_WARN - 30;
        end else if (r < 90) begin
            t = int'($urandom_range(0, 383)) - 128;
        end else begin
            t = $urandom_range(0, 1) ? 255 : -128;
        end
        return t < -128 ? -128 : (t > 255 ? 255 : t);
    endfunction

    function automatic int pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 1500);
        if (r < 90) return $urandom_range(1500, 4000);
        if (r < 95) return 65535;
        return $urandom_range(0, 65535);
    endfunction

    task automatic queue_item(logic [1:0] mode, logic [1:0] host, int vb, int temp,
                              int ivl, logic pin);
        afs_pkg::t_item it;
        it.mode            = mode;
        it.host_state      = host;
        it.battery_voltage = 16'(vb);
        it.temperature     = 9'(temp);
        it.elapsed_ms      = 16'(ivl);
        it.classd_fault    = pin;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Mostly ticks, with class-D episodes that usually run long enough to recover.
    task automatic queue_random(int n, bit with_supply);
        int made;
        int r;
        int k;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (with_supply && r < 5) begin
                queue_item(afs_pkg::MODE_SUPPLY, pick_host(), $urandom_range(0, 65535),
                           pick_temp(), $urandom_range(0, 65535),
                           1'($urandom_range(0, 1)));
                made++;
            end else if (r < 12) begin
                queue_item(afs_pkg::MODE_CLASSD, pick_host(), pick_voltage(), pick_temp(),
                           pick_interval(), 1'b1);
                k = $urandom_range(3, 6);
                repeat (k)
                    queue_item(afs_pkg::MODE_TICK, pick_host(), nominal_voltage(),
                               HOT_WARN - 30, $urandom_range(800, 1600),
                               $urandom_range(0, 99) < 20);
                made += k + 1;
            end else if (r < 20) begin
                queue_item(afs_pkg::MODE_CLASSD, pick_host(), $urandom_range(0, 65535),
                           pick_temp(), $urandom_range(0, 65535),
                           1'($urandom_range(0, 1)));
                made++;
            end else if (r < 23) begin
                queue_item(MODE_UNUSED, pick_host(), $urandom_range(0, 65535), pick_temp(),
                           $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
                made++;
            end else begin
                queue_item(afs_pkg::MODE_TICK, pick_host(), pick_voltage(), pick_temp(),
                           pick_interval(), $urandom_range(0, 99) < 30);
                made++;
            end
        end
    endtask

    // One APB write: setup cycle, then access cycle; the register takes the
    // value at the edge that closes the access cycle.
    task automatic write_level(afs_pkg::t_reg_idx idx, int val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            afs_pkg::REG_OV_PROTECT: lvl.ov_protect = val[15:0];
            afs_pkg::REG_OV_RECOVER: lvl.ov_recover = val[15:0];
            afs_pkg::REG_OV_WARNING: lvl.ov_warning = val[15:0];
            afs_pkg::REG_UV_PROTECT: lvl.uv_protect = val[15:0];
            afs_pkg::REG_UV_RECOVER: lvl.uv_recover = val[15:0];
            afs_pkg::REG_UV_WARNING: lvl.uv_warning = val[15:0];
            afs_pkg::REG_TH_PROTECT: lvl.th_protect = val[8:0];
            afs_pkg::REG_TH_RECOVER: lvl.th_recover = val[8:0];
            default: ;
        endcase
    endtask

    task automatic apply_levels(int ovp, int ovr, int ovw, int uvp, int uvr, int uvw,
                                int thp, int thr);
        write_level(afs_pkg::REG_OV_PROTECT, ovp);
        write_level(afs_pkg::REG_OV_RECOVER, ovr);
        write_level(afs_pkg::REG_OV_WARNING, ovw);
        write_level(afs_pkg::REG_UV_PROTECT, uvp);
        write_level(afs_pkg::REG_UV_RECOVER, uvr);
        write_level(afs_pkg::REG_UV_WARNING, uvw);
        write_level(afs_pkg::REG_TH_PROTECT, thp);
        write_level(afs_pkg::REG_TH_RECOVER, thr);
    endtask

    // Hold until every queued beat went in and its result came back, then
    // let the two pipeline stages settle.
    task automatic wait_drained();
        while (beats_in != items_queued || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void check_field(string what, logic [4:0] exp_v, logic [4:0] got);
        if (got !== exp_v) begin
            errors++;
            // Keep the log bounded if the block is badly broken
            if (errors <= 200)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what,
                         exp_v, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: pop pending beats, hold each until accepted, and run the
    // model on every accepted beat.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            in_beat = i_in_valid && o_in_ready;
            if (in_beat) begin
                expected_status.push_back(supervise_step(drv_item));
                beats_in++;
                tx_gap = pick_idle(tx_quiet);
            end
            if (i_in_valid && !in_beat) begin
                // hold the offered beat unchanged
            end else if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                drv_item = pending_items.pop_front();
                i_mode            <= drv_item.mode;
                i_host_state      <= drv_item.host_state;
                i_battery_voltage <= drv_item.battery_voltage;
                i_temperature     <= drv_item.temperature;
                i_elapsed_ms      <= drv_item.elapsed_ms;
                i_classd_fault    <= drv_item.classd_fault;
                i_in_valid        <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted beat with the oldest expectation,
    // and stall the output side at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            out_beat = o_out_valid && i_out_ready;
            if (out_beat) begin
                if (expected_status.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, {o_in_protection, o_leave_protection, o_restore_state,
                                     o_supply_enable, o_classd_disable, o_amp_off,
                                     o_fault_flags, o_warning_flags});
                end else begin
                    want = expected_status.pop_front();
                    check_field("in_protection", want.in_prot, o_in_protection);
                    check_field("leave_protection", want.left, o_leave_protection);
                    check_field("restore_state", want.restore, o_restore_state);
                    check_field("supply_enable", want.supply_en, o_supply_enable);
                    check_field("classd_disable", want.stage_dis, o_classd_disable);
                    check_field("amp_off", want.amp_off, o_amp_off);
                    check_field("fault_flags", want.fault, o_fault_flags);
                    check_field("warning_flags", want.warn, o_warning_flags);
                end
                rx_wait = pick_idle(rx_quiet);
            end
            if (hold_off) begin
                i_out_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Back-pressure: twice in mid-phase, drop ready for a long stretch while
    // the driver keeps offering beats, so both stages fill and input stalls.
    initial begin
        int hold_points[2];
        hold_points = '{450, 1250};
        foreach (hold_points[k]) begin
            wait (beats_in >= hold_points[k]);
            @(posedge i_clk);
            hold_off <= 1'b1;
            repeat (200) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #LIMIT_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed beats, then random phases under different
    // level settings. The supply over-current latch never clears, so supply
    // events are kept for the last phase.
    // ------------------------------------------------------------------
    initial begin
        sup = afs_pkg::STATE_RST;
        lvl = '{ov_protect: afs_pkg::OV_PROTECT_RST, ov_recover: afs_pkg::OV_RECOVER_RST,
                ov_warning: afs_pkg::OV_WARNING_RST, uv_protect: afs_pkg::UV_PROTECT_RST,
                uv_recover: afs_pkg::UV_RECOVER_RST, uv_warning: afs_pkg::UV_WARNING_RST,
                th_protect: afs_pkg::TH_PROTECT_RST, th_recover: afs_pkg::TH_RECOVER_RST};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apply_levels(40000, 38000, 36000, 10000, 11000, 12000, 100, 85);

        // Over-voltage bands: nominal, warning, upper middle, fault, hold, clear at recover
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 30000, 25, 10, 1'b0);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 37000, 25, 10, 1'b0);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 39000, 25, 10, 1'b0);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 40000, 25, 10, 1'b0);
        queue_item(afs_pkg::MODE_TICK, HOST_OTHER, 39000, 25, 10, 1'b0);
        queue_item(afs_pkg::MODE_TICK, HOST_OTHER, 38000, 25, 10, 1'b0);
        // Field extremes
        queue_item(afs_pkg::MODE_TICK, HOST_INIT, 65535, 255, 65535, 1'b1);
        queue_item(afs_pkg::MODE_TICK, HOST_INIT, 0, -128, 0, 1'b0);
        // Under-voltage middle band with fault held, then clear into warning
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 10500, 25, 10, 1'b0);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 11000, 25, 10, 1'b0);
        // Thermal: middle band warning, top band keeps warning, fault held, clear
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 30000, 90, 10, 1'b0);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 30000, 100, 10, 1'b0);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 30000, 90, 10, 1'b0);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 30000, 80, 10, 1'b0);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 30000, 74, 10, 1'b0);
        // Tick while host is shut down and unprotected: ignored
        queue_item(afs_pkg::MODE_TICK, afs_pkg::HOST_SHUTDOWN, 0, 255, 500, 1'b1);
        // Class-D event without pin fault, then with it
        queue_item(afs_pkg::MODE_CLASSD, HOST_NORMAL, 0, 0, 0, 1'b0);
        queue_item(afs_pkg::MODE_CLASSD, HOST_NORMAL, 30000, 25, 0, 1'b1);
        // Recovery period: pin still faulty, then clear after saturating time
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 30000, 25, 2000, 1'b1);
        queue_item(afs_pkg::MODE_TICK, afs_pkg::HOST_SHUTDOWN, 30000, 25, 1500, 1'b1);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 30000, 25, 65535, 1'b0);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 30000, 25, 10, 1'b0);
        // Unused mode code, then re-entry while already protected
        queue_item(MODE_UNUSED, HOST_OTHER, 65535, -1, 65535, 1'b1);
        queue_item(afs_pkg::MODE_TICK, HOST_OTHER, 40000, 25, 10, 1'b0);
        queue_item(afs_pkg::MODE_CLASSD, HOST_INIT, 30000, 25, 10, 1'b1);
        wait_drained();

        queue_random(280, 1'b0);
        wait_drained();

        // Widest bands
        apply_levels(65535, 65535, 0, 0, 0, 65535, 255, -128);
        queue_random(280, 1'b0);
        wait_drained();

        // Levels at the tripping extremes: over-voltage, under-voltage and thermal always trip
        apply_levels(0, 0, 0, 65535, 65535, 65535, -128, -128);
        queue_random(280, 1'b0);
        wait_drained();

        // Misordered levels
        apply_levels(30000, 32000, 31000, 20000, 19000, 25000, 50, 60);
        queue_random(280, 1'b0);
        wait_drained();

        apply_levels($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     int'($urandom_range(0, 383)) - 128, int'($urandom_range(0, 383)) - 128);
        queue_random(280, 1'b0);
        wait_drained();

        // Narrow bands
        apply_levels(50000, 49990, 49980, 5000, 5010, 5020, 20, -20);
        queue_random(280, 1'b0);
        wait_drained();

        // Supply faults latch for good, so they close the run
        apply_levels(40000, 38000, 36000, 10000, 11000, 12000, 100, 85);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 30000, 25, 10, 1'b0);
        queue_item(afs_pkg::MODE_SUPPLY, HOST_NORMAL, 30000, 25, 10, 1'b0);
        queue_item(afs_pkg::MODE_SUPPLY, HOST_OTHER, 65535, -1, 65535, 1'b1);
        queue_item(afs_pkg::MODE_TICK, HOST_NORMAL, 30000, 25, 4000, 1'b0);
        queue_random(150, 1'b1);
        wait_drained();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> amp_fault_supervisor_top.f
rtl/core/afs_pkg.sv
rtl/core/afs_cfg_regs.sv
rtl/core/afs_update.sv
rtl/core/amp_fault_supervisor_top.sv
test/amp_fault_supervisor_top_tb.sv
